[hw/rtl/xta_pkg.sv]
// ----------------------------------------------------------------------------
// xta_pkg: shared types, constants and field arithmetic for the tweak advance
// GF(2^128) helpers, reduction polynomial x^128 + x^7 + x^2 + x + 1
// ----------------------------------------------------------------------------
package xta_pkg;

  localparam logic [127:0] REDUCE_POLY = 128'h87;
  localparam int unsigned  MUL_DIGIT   = 4;
  localparam int unsigned  MUL_STEPS   = 128 / MUL_DIGIT;
  localparam int unsigned  MUL_CNT_W   = $clog2(MUL_STEPS);

  typedef struct packed {
    logic [63:0] tweak_low;
    logic [63:0] tweak_high;
    logic [63:0] block_offset;
  } xta_req_t;

  typedef struct packed {
    logic [63:0] new_tweak_low;
    logic [63:0] new_tweak_high;
  } xta_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXP,
    ST_MUL,
    ST_DONE
  } xta_state_t;

  // multiply by x with reduction
  function automatic logic [127:0] gf_times_x(input logic [127:0] v);
    gf_times_x = {v[126:0], 1'b0} ^ (v[127] ? REDUCE_POLY : 128'd0);
  endfunction

  // squaring is linear: spread bits, then fold the upper half twice
  function automatic logic [127:0] gf_square(input logic [127:0] v);
    logic [254:0] s;
    logic [126:0] h;
    logic [133:0] t;
    logic [5:0]   f;
    s = '0;
    for (int i = 0; i < 128; i++) begin
      s[2*i] = v[i];
    end
    h = s[254:128];
    t = {6'b0, s[127:0]} ^ {7'b0, h} ^ {6'b0, h, 1'b0} ^ {5'b0, h, 2'b0} ^ {h, 7'b0};
    f = t[133:128];
    gf_square = t[127:0] ^ {122'b0, f} ^ {121'b0, f, 1'b0} ^ {120'b0, f, 2'b0}
              ^ {115'b0, f, 7'b0};
  endfunction

  // one digit of the shift-and-add multiply, top multiplier bit first
  function automatic logic [127:0] gf_mul_digit(input logic [127:0] acc,
                                                input logic [127:0] a,
                                                input logic [MUL_DIGIT-1:0] d);
    logic [127:0] r;
    r = acc;
    for (int j = MUL_DIGIT - 1; j >= 0; j--) begin
      r = gf_times_x(r) ^ (d[j] ? a : 128'd0);
    end
    gf_mul_digit = r;
  endfunction

endpackage

[hw/rtl/xts_tweak_advance_core.sv]
// ----------------------------------------------------------------------------
// xts_tweak_advance_core: advance an XTS tweak by a block offset
// Returns tweak * alpha^offset in GF(2^128) with a small sequencer
// ----------------------------------------------------------------------------
// Usage:
//   Request channel in_valid / in_stall / in_data carries the tweak halves and
//   the block offset; a request is taken when in_valid is high and in_stall
//   is low. The response channel out_valid / out_stall / out_data carries the
//   new tweak; it is taken when out_valid is high and out_stall is low.
// Sequence:
//   The exponent alpha^offset is built by one squarer plus a shift-by-x unit,
//   one offset bit per cycle in ST_EXP, then a 4-bit-per-cycle shift-and-add
//   multiplier folds it into the tweak in ST_MUL. ST_DONE moves the result to
//   the output register once that register is free: a request occupies the
//   core through ST_EXP, ST_MUL and ST_DONE, and the core takes a new request
//   only in ST_IDLE, after the last one has left ST_DONE.
//   in_stall is high while a request is being worked on.
// Stall and reset:
//   A waiting result sits in the output register and the next request can
//   already be taken; a finished result waits in the core until the output
//   register frees up. Reset (rst, synchronous) empties the core and drops
//   any result not yet taken. Offset bits above OFFSET_BITS are ignored.
// ----------------------------------------------------------------------------
module xts_tweak_advance_core #(
  parameter int unsigned OFFSET_BITS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  xta_pkg::xta_req_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output xta_pkg::xta_rsp_t out_data
);

  localparam int unsigned CNT_W = $clog2(OFFSET_BITS);

  xta_pkg::xta_state_t state, state_next;

  logic [OFFSET_BITS-1:0]        offset_sr;
  logic [CNT_W-1:0]              bit_cnt;
  logic [xta_pkg::MUL_CNT_W-1:0] mul_cnt;
  logic [127:0]                  tweak;
  logic [127:0]                  power;
  logic [127:0]                  acc;

  logic take_req;
  logic out_free;
  logic load_out;
  logic [127:0] power_sq;

  assign out_free = !out_valid || !out_stall;
  assign take_req = in_valid && !in_stall;
  assign power_sq = xta_pkg::gf_square(power);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      xta_pkg::ST_IDLE: begin
        if (in_valid) state_next = xta_pkg::ST_EXP;
      end
      xta_pkg::ST_EXP: begin
        if (bit_cnt == '0) state_next = xta_pkg::ST_MUL;
      end
      xta_pkg::ST_MUL: begin
        if (mul_cnt == xta_pkg::MUL_CNT_W'(xta_pkg::MUL_STEPS - 1)) begin
          state_next = xta_pkg::ST_DONE;
        end
      end
      xta_pkg::ST_DONE: begin
        if (out_free) state_next = xta_pkg::ST_IDLE;
      end
      default: state_next = xta_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    case (state)
      xta_pkg::ST_IDLE: in_stall = 1'b0;
      xta_pkg::ST_EXP:  in_stall = 1'b1;
      xta_pkg::ST_MUL:  in_stall = 1'b1;
      xta_pkg::ST_DONE: load_out = out_free;
      default:          in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xta_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (take_req) begin
      offset_sr <= in_data.block_offset[OFFSET_BITS-1:0];
      tweak     <= {in_data.tweak_high, in_data.tweak_low};
      power     <= 128'd1;
      acc       <= '0;
      bit_cnt   <= CNT_W'(OFFSET_BITS - 1);
      mul_cnt   <= '0;
    end else if (state == xta_pkg::ST_EXP) begin
      // square, then one more factor of x when the offset bit is set
      power     <= offset_sr[OFFSET_BITS-1] ? xta_pkg::gf_times_x(power_sq) : power_sq;
      offset_sr <= {offset_sr[OFFSET_BITS-2:0], 1'b0};
      bit_cnt   <= bit_cnt - 1'b1;
    end else if (state == xta_pkg::ST_MUL) begin
      acc     <= xta_pkg::gf_mul_digit(acc, tweak, power[127 -: xta_pkg::MUL_DIGIT]);
      power   <= {power[127-xta_pkg::MUL_DIGIT:0], {xta_pkg::MUL_DIGIT{1'b0}}};
      mul_cnt <= mul_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.new_tweak_low  <= acc[63:0];
      out_data.new_tweak_high <= acc[127:64];
    end
  end

`ifndef SYNTH
  a_req_starts_exp: assert property (@(posedge clk) disable iff (rst)
    take_req |=> state == xta_pkg::ST_EXP)
    else $error("request did not start the exponent phase");

  a_exp_to_mul: assert property (@(posedge clk) disable iff (rst)
    (state == xta_pkg::ST_EXP && bit_cnt == '0) |=> state == xta_pkg::ST_MUL)
    else $error("exponent phase did not hand over to the multiplier");

  a_mul_to_done: assert property (@(posedge clk) disable iff (rst)
    (state == xta_pkg::ST_MUL && mul_cnt == xta_pkg::MUL_CNT_W'(xta_pkg::MUL_STEPS - 1))
    |=> state == xta_pkg::ST_DONE)
    else $error("multiplier ran past its last digit");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == xta_pkg::ST_DONE)
    else $error("response raised without a finished request");

  a_no_req_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != xta_pkg::ST_IDLE) |-> in_stall)
    else $error("request channel open while busy");
`endif

endmodule
